// ----- sv/psb_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the palette sprite blitter.
// No dependencies; imported by every module of the block.
package psb_pkg;

	localparam int SCREEN_WIDTH      = 280;
	localparam int SCREEN_HEIGHT     = 240;
	localparam int TRANSPARENT_INDEX = 234;
	localparam int PALETTE_DEPTH     = 256;

	localparam int COLOR_W = 8;
	localparam int SX_W    = 9;
	localparam int SY_W    = 8;
	localparam int COORD_W = 18;
	localparam int CFG_W   = 16;

	typedef enum logic [1:0] {
		OP_PIXEL     = 2'd0,
		OP_PAL_WRITE = 2'd1,
		OP_PAL_RESET = 2'd2,
		OP_NONE      = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_HALF   = 2'd1,
		MODE_SCALED = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		CFG_SPRITE_WIDTH  = 3'd0,
		CFG_SPRITE_HEIGHT = 3'd1,
		CFG_X_OFFSET      = 3'd2,
		CFG_Y_OFFSET      = 3'd3,
		CFG_FLIP_SELECT   = 3'd4,
		CFG_DRAW_MODE     = 3'd5,
		CFG_X_SCALE       = 3'd6,
		CFG_Y_SCALE       = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic               wr;
		logic               clr;
		logic               rd;
		logic [COLOR_W-1:0] addr;
		logic [COLOR_W-1:0] wdata;
	} pal_req_t;

	typedef struct packed {
		logic                      skip;
		logic signed [COORD_W-1:0] bx;
		logic signed [COORD_W-1:0] by;
		logic [2:0]                xs_m1;
		logic [2:0]                ys_m1;
		logic                      done;
	} item_t;

endpackage

// ----- sv/psb_palette.sv -----
`timescale 1ns / 1ps
// Palette table: 256 x 8 synchronous RAM with per-entry valid bits.
// An entry not written since reset or a palette reset reads as its own index.
module psb_palette import psb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  pal_req_t           req,
	output logic [COLOR_W-1:0] color
);

	logic [COLOR_W-1:0] mem [256];
	logic [255:0]       vld_q;
	logic [COLOR_W-1:0] data_q;
	logic [COLOR_W-1:0] addr_q;
	logic               hit_q;

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd) begin
			data_q <= mem[req.addr];
			addr_q <= req.addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (req.clr) begin
				for (int i = 0; i < PALETTE_DEPTH; i++) begin
					vld_q[i] <= 1'b0;
				end
			end else if (req.wr) begin
				vld_q[req.addr] <= 1'b1;
			end
			if (req.rd) begin
				hit_q <= vld_q[req.addr];
			end
		end
	end

	assign color = hit_q ? data_q : addr_q;

endmodule

// ----- sv/palette_sprite_blitter_top.sv -----
`timescale 1ns / 1ps
// Top level of the palette sprite blitter.
// Depends on psb_pkg and psb_palette.
//
// Takes one beat per cycle while in_ready is high. Palette write and palette
// reset beats finish in the cycle they are accepted. A pixel beat reads the
// palette RAM, then enters a run stage that emits one result per cycle while
// out_ready does not stall it: one result in normal and half mode, x_scale *
// y_scale results in scaled mode. Its first result passes the palette read
// register, the run stage and the output register. The user must write
// configuration only while no pixel is in flight; the block does not enforce it.
module palette_sprite_blitter_top import psb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic [COLOR_W-1:0] color_index,
	input  logic [COLOR_W-1:0] new_color,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               write_enable,
	output logic [SX_W-1:0]    screen_x,
	output logic [SY_W-1:0]    screen_y,
	output logic [COLOR_W-1:0] pixel_color,
	output logic               last_of_run,
	output logic               sprite_done
);

	localparam logic signed [COORD_W-1:0] SCR_W_C = COORD_W'(SCREEN_WIDTH);
	localparam logic signed [COORD_W-1:0] SCR_H_C = COORD_W'(SCREEN_HEIGHT);

	function automatic logic [9:0] clamp_size(input logic [9:0] v);
		logic [9:0] r;
		r = v;
		if (v == 10'd0) begin
			r = 10'd1;
		end else if (v > 10'd512) begin
			r = 10'd512;
		end
		return r;
	endfunction

	function automatic logic [3:0] clamp_scale(input logic [3:0] v);
		logic [3:0] r;
		r = v;
		if (v == 4'd0) begin
			r = 4'd1;
		end else if (v > 4'd8) begin
			r = 4'd8;
		end
		return r;
	endfunction

	logic [9:0]        sprite_width_q, sprite_height_q;
	logic [15:0]       x_offset_q, y_offset_q;
	logic [1:0]        flip_select_q, draw_mode_q;
	logic [3:0]        x_scale_q, y_scale_q;
	logic [8:0]        col_q, row_q;

	logic              valid_s1, valid_s2;
	item_t             item_s1, item_s2;
	logic [COLOR_W-1:0] color_s2;
	logic [2:0]        dx_s2, dy_s2;

	logic               out_valid_q, we_q, last_q, done_q;
	logic [SX_W-1:0]    sx_q;
	logic [SY_W-1:0]    sy_q;
	logic [COLOR_W-1:0] pc_q;

	logic               acc, pix_acc;
	pal_req_t           pal_req;
	logic [COLOR_W-1:0] pal_color;

	logic [9:0]  w, h;
	logic [3:0]  xs, ys;
	logic        row_end, done;
	logic signed [COORD_W-1:0] xo, yo, w_s, h_s, c_s, r_s, cc, rr;
	logic [12:0] cx, ry;
	logic        half_ok;
	item_t       item_n;

	logic        emit, s2_last, s2_free, s1_adv;
	logic signed [COORD_W-1:0] rx, ryy;
	logic        on_scr;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sprite_width_q  <= 10'd1;
			sprite_height_q <= 10'd1;
			x_offset_q      <= '0;
			y_offset_q      <= '0;
			flip_select_q   <= '0;
			draw_mode_q     <= '0;
			x_scale_q       <= 4'd1;
			y_scale_q       <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SPRITE_WIDTH:  sprite_width_q  <= cfg_data[9:0];
				CFG_SPRITE_HEIGHT: sprite_height_q <= cfg_data[9:0];
				CFG_X_OFFSET:      x_offset_q      <= cfg_data[15:0];
				CFG_Y_OFFSET:      y_offset_q      <= cfg_data[15:0];
				CFG_FLIP_SELECT:   flip_select_q   <= cfg_data[1:0];
				CFG_DRAW_MODE:     draw_mode_q     <= cfg_data[1:0];
				CFG_X_SCALE:       x_scale_q       <= cfg_data[3:0];
				CFG_Y_SCALE:       y_scale_q       <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// handshake and stage control
	assign emit    = valid_s2 && (!out_valid_q || out_ready);
	assign s2_last = (dx_s2 == item_s2.xs_m1) && (dy_s2 == item_s2.ys_m1);
	assign s2_free = !valid_s2 || (emit && s2_last);
	assign s1_adv  = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;
	assign acc      = in_valid && in_ready;
	assign pix_acc  = acc && (op_t'(operation) == OP_PIXEL);

	always_comb begin
		pal_req       = '0;
		pal_req.addr  = color_index;
		pal_req.wdata = new_color;
		pal_req.rd    = pix_acc;
		pal_req.wr    = acc && (op_t'(operation) == OP_PAL_WRITE);
		pal_req.clr   = acc && (op_t'(operation) == OP_PAL_RESET);
	end

	psb_palette u_palette (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (pal_req),
		.color  (pal_color)
	);

	// placement of the accepted pixel
	always_comb begin
		w   = clamp_size(sprite_width_q);
		h   = clamp_size(sprite_height_q);
		xs  = clamp_scale(x_scale_q);
		ys  = clamp_scale(y_scale_q);
		row_end = ({1'b0, col_q} + 10'd1) >= w;
		done    = row_end && (({1'b0, row_q} + 10'd1) >= h);
		xo  = COORD_W'($signed(x_offset_q));
		yo  = COORD_W'($signed(y_offset_q));
		w_s = $signed({{(COORD_W-10){1'b0}}, w});
		h_s = $signed({{(COORD_W-10){1'b0}}, h});
		c_s = $signed({{(COORD_W-9){1'b0}}, col_q});
		r_s = $signed({{(COORD_W-9){1'b0}}, row_q});
		cc  = flip_select_q[0] ? (w_s - COORD_W'(1) - c_s) : c_s;
		rr  = flip_select_q[1] ? (h_s - COORD_W'(1) - r_s) : r_s;
		cx  = 13'(col_q) * 13'(xs);
		ry  = 13'(row_q) * 13'(ys);
		half_ok = !col_q[0] && !row_q[0] && ({1'b0, col_q[8:1]} < w[9:1])
			&& ({1'b0, row_q[8:1]} < h[9:1]);

		item_n       = '0;
		item_n.done  = done;
		case (mode_t'(draw_mode_q))
			MODE_HALF: begin
				item_n.skip = !half_ok;
				item_n.bx   = xo + $signed({{(COORD_W-8){1'b0}}, col_q[8:1]});
				item_n.by   = yo + $signed({{(COORD_W-8){1'b0}}, row_q[8:1]});
			end
			MODE_SCALED: begin
				item_n.bx    = xo + $signed({{(COORD_W-13){1'b0}}, cx});
				item_n.by    = yo + $signed({{(COORD_W-13){1'b0}}, ry});
				item_n.xs_m1 = 3'(xs - 4'd1);
				item_n.ys_m1 = 3'(ys - 4'd1);
			end
			default: begin
				item_n.bx = xo + cc;
				item_n.by = yo + rr;
			end
		endcase
	end

	// source counters and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			dx_s2       <= '0;
			dy_s2       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pix_acc) begin
				if (row_end) begin
					col_q <= '0;
					row_q <= done ? 9'd0 : 9'(row_q + 9'd1);
				end else begin
					col_q <= 9'(col_q + 9'd1);
				end
			end

			if (pix_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end

			if (s1_adv) begin
				valid_s2 <= 1'b1;
				dx_s2    <= '0;
				dy_s2    <= '0;
			end else if (emit) begin
				if (s2_last) begin
					valid_s2 <= 1'b0;
				end else if (dx_s2 == item_s2.xs_m1) begin
					dx_s2 <= '0;
					dy_s2 <= 3'(dy_s2 + 3'd1);
				end else begin
					dx_s2 <= 3'(dx_s2 + 3'd1);
				end
			end

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			item_s1 <= item_n;
		end
		if (s1_adv) begin
			item_s2  <= item_s1;
			color_s2 <= pal_color;
		end
	end

	// result of the run stage
	always_comb begin
		rx     = item_s2.bx + $signed({{(COORD_W-3){1'b0}}, dx_s2});
		ryy    = item_s2.by + $signed({{(COORD_W-3){1'b0}}, dy_s2});
		on_scr = !rx[COORD_W-1] && (rx < SCR_W_C) && !ryy[COORD_W-1] && (ryy < SCR_H_C);
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			last_q <= s2_last;
			done_q <= item_s2.done;
			if (item_s2.skip) begin
				we_q <= 1'b0;
				sx_q <= '0;
				sy_q <= '0;
				pc_q <= '0;
			end else begin
				we_q <= on_scr && (color_s2 != COLOR_W'(TRANSPARENT_INDEX));
				sx_q <= on_scr ? rx[SX_W-1:0] : '0;
				sy_q <= on_scr ? ryy[SY_W-1:0] : '0;
				pc_q <= color_s2;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign write_enable = we_q;
	assign screen_x     = sx_q;
	assign screen_y     = sy_q;
	assign pixel_color  = pc_q;
	assign last_of_run  = last_q;
	assign sprite_done  = done_q;

endmodule

// ----- sv/psb_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the palette sprite blitter, bound to the top level.
// Depends on psb_pkg.
module psb_assert import psb_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic               write_enable,
	input logic [SX_W-1:0]    screen_x,
	input logic [SY_W-1:0]    screen_y,
	input logic [COLOR_W-1:0] pixel_color,
	input logic               last_of_run,
	input logic               sprite_done
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(write_enable)
			&& $stable(screen_x) && $stable(screen_y) && $stable(pixel_color)
			&& $stable(last_of_run) && $stable(sprite_done))
		else $error("result beat changed while stalled");

	a_we_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_enable |-> pixel_color != COLOR_W'(TRANSPARENT_INDEX))
		else $error("transparent color written");

	a_we_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_enable |-> (screen_x < SX_W'(SCREEN_WIDTH))
			&& (screen_y < SY_W'(SCREEN_HEIGHT)))
		else $error("write outside the screen");

	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_enable && pixel_color != COLOR_W'(TRANSPARENT_INDEX)
			|-> screen_x == '0 && screen_y == '0)
		else $error("disabled opaque result carries a coordinate");

endmodule

bind palette_sprite_blitter_top psb_assert u_psb_assert (.*);

// ----- sim/psb_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the palette sprite blitter: tracks config, palette and raster
// position, predicts every target pixel and compares output beats in order.
// Depends on psb_pkg.
module psb_checker import psb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         operation,
	input  logic [COLOR_W-1:0] color_index,
	input  logic [COLOR_W-1:0] new_color,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               write_enable,
	input  logic [SX_W-1:0]    screen_x,
	input  logic [SY_W-1:0]    screen_y,
	input  logic [COLOR_W-1:0] pixel_color,
	input  logic               last_of_run,
	input  logic               sprite_done,
	output int                 mismatches,
	output int                 outstanding
);

	typedef struct packed {
		logic               we;
		logic [SX_W-1:0]    sx;
		logic [SY_W-1:0]    sy;
		logic [COLOR_W-1:0] color;
		logic               last;
		logic               done;
	} target_px_t;

	logic [COLOR_W-1:0] palette [256];
	logic [8:0]         src_col;
	logic [8:0]         src_row;
	logic [9:0]         width_reg;
	logic [9:0]         height_reg;
	logic [15:0]        xoff_reg;
	logic [15:0]        yoff_reg;
	logic [1:0]         flip_reg;
	logic [1:0]         mode_reg;
	logic [3:0]         xscale_reg;
	logic [3:0]         yscale_reg;
	target_px_t         pending_px [$];
	int                 fail_total;

	function automatic int clamp_int(int v, int lo, int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic target_px_t place_px(int x, int y, logic [COLOR_W-1:0] color,
			logic last, logic done);
		target_px_t p;
		logic       on;
		on = x >= 0 && x < SCREEN_WIDTH && y >= 0 && y < SCREEN_HEIGHT;
		p.we    = on && (color != COLOR_W'(TRANSPARENT_INDEX));
		p.sx    = on ? SX_W'(x) : '0;
		p.sy    = on ? SY_W'(y) : '0;
		p.color = color;
		p.last  = last;
		p.done  = done;
		return p;
	endfunction

	task automatic blit_pixel(input logic [COLOR_W-1:0] idx);
		int                 w, h, c, r, xo, yo, xs, ys, cc, rr;
		logic               row_end, done;
		logic [COLOR_W-1:0] color;
		target_px_t         skip_px;
		w       = clamp_int(int'(width_reg), 1, 512);
		h       = clamp_int(int'(height_reg), 1, 512);
		c       = int'(src_col);
		r       = int'(src_row);
		row_end = (c + 1 >= w);
		done    = row_end && (r + 1 >= h);
		color   = palette[idx];
		xo      = int'($signed(xoff_reg));
		yo      = int'($signed(yoff_reg));
		case (mode_reg)
			MODE_HALF: begin
				if (c % 2 == 0 && r % 2 == 0 && c / 2 < w / 2 && r / 2 < h / 2) begin
					pending_px.push_back(place_px(xo + c / 2, yo + r / 2, color, 1'b1, done));
				end else begin
					skip_px      = '0;
					skip_px.last = 1'b1;
					skip_px.done = done;
					pending_px.push_back(skip_px);
				end
			end
			MODE_SCALED: begin
				xs = clamp_int(int'(xscale_reg), 1, 8);
				ys = clamp_int(int'(yscale_reg), 1, 8);
				for (int dy = 0; dy < ys; dy++) begin
					for (int dx = 0; dx < xs; dx++) begin
						pending_px.push_back(place_px(xo + c * xs + dx, yo + r * ys + dy, color,
							(dy == ys - 1) && (dx == xs - 1), done));
					end
				end
			end
			default: begin
				cc = flip_reg[0] ? (w - 1 - c) : c;
				rr = flip_reg[1] ? (h - 1 - r) : r;
				pending_px.push_back(place_px(xo + cc, yo + rr, color, 1'b1, done));
			end
		endcase
		if (row_end) begin
			src_col = '0;
			src_row = done ? '0 : 9'(r + 1);
		end else begin
			src_col = 9'(c + 1);
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			fail_total++;
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		target_px_t want_px;
		if (!arst_n) begin
			for (int i = 0; i < 256; i++)
				palette[i] = COLOR_W'(i);
			src_col    = '0;
			src_row    = '0;
			width_reg  = 10'd1;
			height_reg = 10'd1;
			xoff_reg   = '0;
			yoff_reg   = '0;
			flip_reg   = '0;
			mode_reg   = MODE_NORMAL;
			xscale_reg = 4'd1;
			yscale_reg = 4'd1;
			pending_px.delete();
			fail_total = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_SPRITE_WIDTH:  width_reg  = cfg_data[9:0];
					CFG_SPRITE_HEIGHT: height_reg = cfg_data[9:0];
					CFG_X_OFFSET:      xoff_reg   = cfg_data[15:0];
					CFG_Y_OFFSET:      yoff_reg   = cfg_data[15:0];
					CFG_FLIP_SELECT:   flip_reg   = cfg_data[1:0];
					CFG_DRAW_MODE:     mode_reg   = cfg_data[1:0];
					CFG_X_SCALE:       xscale_reg = cfg_data[3:0];
					CFG_Y_SCALE:       yscale_reg = cfg_data[3:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				case (op_t'(operation))
					OP_PIXEL:     blit_pixel(color_index);
					OP_PAL_WRITE: palette[color_index] = new_color;
					OP_PAL_RESET: begin
						for (int i = 0; i < PALETTE_DEPTH; i++)
							palette[i] = COLOR_W'(i);
					end
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (pending_px.size() == 0) begin
					fail_total++;
					$error("result beat with no pixel pending: x=%0d y=%0d color=%0d",
						screen_x, screen_y, pixel_color);
				end else begin
					want_px = pending_px.pop_front();
					check_field("write_enable", 16'(want_px.we), 16'(write_enable));
					check_field("screen_x", 16'(want_px.sx), 16'(screen_x));
					check_field("screen_y", 16'(want_px.sy), 16'(screen_y));
					check_field("pixel_color", 16'(want_px.color), 16'(pixel_color));
					check_field("last_of_run", 16'(want_px.last), 16'(last_of_run));
					check_field("sprite_done", 16'(want_px.done), 16'(sprite_done));
				end
			end
			mismatches  <= fail_total;
			outstanding <= pending_px.size();
		end
	end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench top for the palette sprite blitter: clock, reset, stimulus, output
// back-pressure and verdict. Depends on psb_pkg, psb_checker and the block.
module tb_top;
	import psb_pkg::*;

	localparam int             HALF_PERIOD     = 10;
	localparam int             WATCHDOG_LIMIT  = 5000;
	localparam int             HOLD_OFF_CYCLES = 400;
	localparam int             DRAIN_CYCLES    = 16;
	localparam int             RANDOM_ITEMS    = 150;
	localparam logic [1:0]     MODE_UNUSED     = 2'd3;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [CFG_W-1:0]   cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         operation;
	logic [COLOR_W-1:0] color_index;
	logic [COLOR_W-1:0] new_color;
	logic               out_valid;
	logic               out_ready;
	logic               write_enable;
	logic [SX_W-1:0]    screen_x;
	logic [SY_W-1:0]    screen_y;
	logic [COLOR_W-1:0] pixel_color;
	logic               last_of_run;
	logic               sprite_done;

	int mismatches;
	int outstanding;
	int hold_req = 0;
	int hold_seen;
	int idle_cycles = 0;
	int beats_sent = 0;
	bit no_gaps = 1'b0;

	always #HALF_PERIOD clk = ~clk;

	palette_sprite_blitter_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.color_index  (color_index),
		.new_color    (new_color),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.write_enable (write_enable),
		.screen_x     (screen_x),
		.screen_y     (screen_y),
		.pixel_color  (pixel_color),
		.last_of_run  (last_of_run),
		.sprite_done  (sprite_done)
	);

	psb_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.color_index  (color_index),
		.new_color    (new_color),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.write_enable (write_enable),
		.screen_x     (screen_x),
		.screen_y     (screen_y),
		.pixel_color  (pixel_color),
		.last_of_run  (last_of_run),
		.sprite_done  (sprite_done),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] add_noise(int val, int width);
		if ($urandom_range(0, 3) == 0)
			return 16'(val) | (16'($urandom) << width);
		return 16'(val);
	endfunction

	function automatic logic [15:0] sprite_size(int typical);
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return add_noise($urandom_range(1, typical), 10);
		else if (r < 90)
			return add_noise(0, 10);
		else if (r < 95)
			return add_noise($urandom_range(513, 1023), 10);
		return add_noise($urandom_range(200, 512), 10);
	endfunction

	function automatic logic [15:0] screen_offset(int span);
		if ($urandom_range(0, 99) < 85)
			return 16'($urandom_range(0, span + 40) - 20);
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] scale_val();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return add_noise($urandom_range(1, 3), 4);
		else if (r < 90)
			return add_noise($urandom_range(4, 8), 4);
		else if (r < 95)
			return add_noise(0, 4);
		return add_noise($urandom_range(9, 15), 4);
	endfunction

	task automatic program_regs(input logic [15:0] w, input logic [15:0] h,
			input logic [15:0] xo, input logic [15:0] yo, input logic [15:0] flip,
			input logic [15:0] mode, input logic [15:0] xs, input logic [15:0] ys);
		logic [CFG_W-1:0] regs [8];
		regs[CFG_SPRITE_WIDTH]  = w;
		regs[CFG_SPRITE_HEIGHT] = h;
		regs[CFG_X_OFFSET]      = xo;
		regs[CFG_Y_OFFSET]      = yo;
		regs[CFG_FLIP_SELECT]   = flip;
		regs[CFG_DRAW_MODE]     = mode;
		regs[CFG_X_SCALE]       = xs;
		regs[CFG_Y_SCALE]       = ys;
		cfg_we <= 1'b1;
		for (int i = 0; i < 8; i++) begin
			cfg_index <= 3'(i);
			cfg_data  <= regs[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic random_regs();
		int         r;
		logic [1:0] mode;
		r = $urandom_range(0, 99);
		mode = (r < 30) ? MODE_NORMAL : (r < 55) ? MODE_HALF :
			(r < 92) ? MODE_SCALED : MODE_UNUSED;
		program_regs(sprite_size(12), sprite_size(8), screen_offset(SCREEN_WIDTH),
			screen_offset(SCREEN_HEIGHT), add_noise($urandom_range(0, 3), 2),
			add_noise(int'(mode), 2), scale_val(), scale_val());
	endtask

	// hold the beat until accepted, then sometimes idle for a random gap
	task automatic send_item(input op_t op, input logic [COLOR_W-1:0] ci,
			input logic [COLOR_W-1:0] nc);
		int gap;
		in_valid    <= 1'b1;
		operation   <= op;
		color_index <= ci;
		new_color   <= nc;
		do @(posedge clk); while (!in_ready);
		if (op != OP_NONE)
			beats_sent++;
		gap = (no_gaps || $urandom_range(0, 99) < 55) ? 0 : pause_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic random_item();
		int r;
		r = $urandom_range(0, 99);
		if (r < 78)
			send_item(OP_PIXEL, ($urandom_range(0, 9) == 0) ? COLOR_W'(TRANSPARENT_INDEX) :
				COLOR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255)));
		else if (r < 90)
			send_item(OP_PAL_WRITE, COLOR_W'($urandom_range(0, 255)),
				($urandom_range(0, 3) == 0) ? COLOR_W'(TRANSPARENT_INDEX) :
				COLOR_W'($urandom_range(0, 255)));
		else if (r < 95)
			send_item(OP_PAL_RESET, COLOR_W'($urandom_range(0, 255)),
				COLOR_W'($urandom_range(0, 255)));
		else
			send_item(OP_NONE, COLOR_W'($urandom_range(0, 255)),
				COLOR_W'($urandom_range(0, 255)));
	endtask

	// drop valid, drain all pending pixels, let palette beats retire
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int start_beats;
		int phase;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = CFG_SPRITE_WIDTH;
		cfg_data    = '0;
		in_valid    = 1'b0;
		operation   = OP_PIXEL;
		color_index = '0;
		new_color   = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bottom-right screen corner, transparency and clipping
		program_regs(16'd3, 16'd2, 16'd278, 16'd238, 16'd0, 16'(MODE_NORMAL), 16'd1, 16'd1);
		send_item(OP_PAL_WRITE, 8'd5, COLOR_W'(TRANSPARENT_INDEX));
		send_item(OP_PIXEL, 8'd5, 8'h00);
		send_item(OP_PIXEL, 8'hFF, 8'hFF);
		send_item(OP_PIXEL, 8'h00, 8'h00);
		send_item(OP_PIXEL, 8'hAA, 8'h55);
		send_item(OP_NONE, 8'hFF, 8'hFF);
		send_item(OP_PIXEL, 8'h55, 8'hAA);
		send_item(OP_PIXEL, 8'd5, 8'h00);
		settle();

		// oversized width, zero height, extreme offsets, both mirrors
		program_regs(16'h03FF, 16'h0000, 16'h8000, 16'h7FFF, 16'd3, 16'(MODE_NORMAL),
			16'd1, 16'd1);
		send_item(OP_PAL_RESET, 8'h00, 8'h00);
		send_item(OP_PIXEL, 8'd5, 8'h00);
		send_item(OP_PIXEL, COLOR_W'(TRANSPARENT_INDEX), 8'h00);
		settle();

		// shrink below the current column, mirrored on screen
		program_regs(16'd2, 16'd2, 16'd10, 16'd20, 16'd3, 16'(MODE_NORMAL), 16'd1, 16'd1);
		repeat (4) send_item(OP_PIXEL, COLOR_W'($urandom_range(0, 255)), 8'h00);
		settle();

		program_regs(16'd5, 16'd3, 16'hFFFF, 16'd0, 16'd0, 16'(MODE_HALF), 16'd1, 16'd1);
		repeat (6) send_item(OP_PIXEL, COLOR_W'($urandom_range(0, 255)), 8'h00);
		settle();

		program_regs(16'd2, 16'd1, 16'd270, 16'd235, 16'd0, 16'(MODE_SCALED), 16'd8, 16'd8);
		repeat (2) send_item(OP_PIXEL, COLOR_W'($urandom_range(0, 255)), 8'h00);
		settle();

		program_regs(16'd1, 16'd1, 16'd0, 16'd0, 16'd1, 16'(MODE_UNUSED), 16'd0, 16'd15);
		repeat (2) send_item(OP_PIXEL, COLOR_W'($urandom_range(0, 255)), 8'h00);
		settle();

		program_regs(16'd2, 16'd2, 16'd100, 16'd100, 16'd0, 16'(MODE_SCALED), 16'd0, 16'd15);
		send_item(OP_PIXEL, COLOR_W'($urandom_range(0, 255)), 8'h00);
		settle();

		start_beats = beats_sent;
		phase = 0;
		while (beats_sent - start_beats < RANDOM_ITEMS) begin
			random_regs();
			no_gaps = ($urandom_range(0, 3) == 0);
			if (phase == 1) begin
				hold_req = hold_req + 1;
				no_gaps = 1'b1;
				wait (hold_seen == hold_req);
			end
			repeat ($urandom_range(8, 30)) random_item();
			settle();
			phase++;
		end

		if (mismatches == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		int r;
		out_ready = 1'b0;
		hold_seen = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else if (r < 10) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(60, 150)) @(posedge clk);
			end else if (r < 70) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end else begin
				out_ready <= 1'b0;
				repeat (pause_len()) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
